FILE: rtl/core/lpcz_pkg.sv
// Shared types, constants and helper functions of the lidar collision zone classifier.
// Used by the config block, the zone test and the top level.
// No dependencies.
package lpcz_pkg;

  // Number of speed bands, and the index width that follows from it
  localparam int SPEED_BANDS = 4;
  localparam int BAND_W      = $clog2(SPEED_BANDS);

  // Field widths
  localparam int COORD_W = 18;   // signed zone bounds and coordinates, doubled y included
  localparam int RSQ_W   = 27;   // squared radius
  localparam int SPD_W   = 32;   // squared speed
  localparam int DIST_W  = 33;   // dx^2 + y^2
  localparam int CFG_W   = 64;   // config write data
  localparam int CFG_IDX_W = 3;

  // Squared band limits (300, 1000 and 2000 mm/s)
  localparam logic [SPD_W-1:0] BAND_LIMIT_SQ [3] = '{32'd90000, 32'd1000000, 32'd4000000};

  // Input modes
  typedef enum logic [1:0] {
    MODE_SPEED = 2'd0,
    MODE_POINT = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_e;

  // Result codes
  typedef enum logic [1:0] {
    FLAG_CLEAR   = 2'd0,
    FLAG_CAUTION = 2'd1,
    FLAG_DANGER  = 2'd2
  } flag_e;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAR_OFFSET  = 3'd0,
    CFG_VEH_LENGTH   = 3'd1,
    CFG_VEH_WIDTH    = 3'd2,
    CFG_CAU_FRONT    = 3'd3,
    CFG_CAU_SIDE     = 3'd4,
    CFG_CAU_REAR     = 3'd5,
    CFG_CAU_RADIUS   = 3'd6,
    CFG_DANGER_TABLE = 3'd7
  } cfg_idx_e;

  // Config reset values
  localparam logic signed [12:0] RST_REAR_OFFSET = -13'sd100;
  localparam logic        [12:0] RST_VEH_LENGTH  = 13'd1100;
  localparam logic        [11:0] RST_VEH_WIDTH   = 12'd700;
  localparam logic signed [13:0] RST_CAU_FRONT   = 14'sd2000;
  localparam logic signed [12:0] RST_CAU_SIDE    = 13'sd500;
  localparam logic signed [12:0] RST_CAU_REAR    = -13'sd1000;
  localparam logic        [12:0] RST_CAU_RADIUS  = 13'd800;
  localparam logic    [CFG_W-1:0] RST_DANGER_TABLE = 64'h5096_4678_3C3C_320A;

  // Precomputed zone bounds; half2 is twice the half-width
  typedef struct packed {
    logic signed [COORD_W-1:0] rear;
    logic signed [COORD_W-1:0] front;
    logic signed [COORD_W-1:0] half2;
    logic        [RSQ_W-1:0]   rad_sq;
  } zone_t;

  // Caution zone from the raw registers
  function automatic zone_t caution_zone(
    input logic signed [12:0] offset,
    input logic        [12:0] length,
    input logic        [11:0] width,
    input logic signed [13:0] fext,
    input logic signed [12:0] sext,
    input logic signed [12:0] rext,
    input logic        [12:0] rad
  );
    zone_t z;
    logic signed [COORD_W-1:0] off_e, len_e, wid_e, fext_e, sext_e, rext_e;
    logic [25:0] rsq;
    off_e  = COORD_W'(offset);
    len_e  = signed'(COORD_W'(length));
    wid_e  = signed'(COORD_W'(width));
    fext_e = COORD_W'(fext);
    sext_e = COORD_W'(sext);
    rext_e = COORD_W'(rext);
    rsq    = 26'(rad) * 26'(rad);
    z.rear   = off_e - rext_e;
    z.front  = off_e + len_e + fext_e;
    z.half2  = wid_e + (sext_e <<< 1);
    z.rad_sq = RSQ_W'(rsq);
    return z;
  endfunction

  // Danger zone for one 16-bit table entry: low byte front cm, high byte radius cm
  function automatic zone_t danger_zone(
    input logic signed [12:0] offset,
    input logic        [12:0] length,
    input logic        [11:0] width,
    input logic        [15:0] entry
  );
    zone_t z;
    logic signed [COORD_W-1:0] off_e, len_e, fr_e;
    logic [11:0] fr_mm, rad_mm;
    logic [23:0] rsq;
    fr_mm  = {1'b0, entry[7:0], 3'b0} + {3'b0, entry[7:0], 1'b0};
    rad_mm = {1'b0, entry[15:8], 3'b0} + {3'b0, entry[15:8], 1'b0};
    off_e  = COORD_W'(offset);
    len_e  = signed'(COORD_W'(length));
    fr_e   = signed'(COORD_W'(fr_mm));
    rsq    = 24'(rad_mm) * 24'(rad_mm);
    z.rear   = off_e;
    z.front  = off_e + len_e + fr_e;
    z.half2  = signed'(COORD_W'(width));
    z.rad_sq = RSQ_W'(rsq);
    return z;
  endfunction

  // Speed band: first limit whose square exceeds s2, else the top band
  function automatic logic [BAND_W-1:0] band_of(input logic [SPD_W-1:0] s2);
    logic [BAND_W-1:0] b;
    logic found;
    b     = BAND_W'(SPEED_BANDS - 1);
    found = 1'b0;
    for (int i = 0; i < SPEED_BANDS - 1; i++) begin
      if (!found && s2 < BAND_LIMIT_SQ[i]) begin
        b     = BAND_W'(i);
        found = 1'b1;
      end
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/lpcz_if.sv
// Valid/ready channel interfaces for point items in and result items out.
// Depends on nothing; field widths are those of the item fields.
interface lpcz_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               last_point;

  modport source (output valid, mode, speed_x, speed_y, point_x, point_y, last_point,
                  input ready);
  modport sink   (input valid, mode, speed_x, speed_y, point_x, point_y, last_point,
                  output ready);
endinterface

interface lpcz_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] collision_flag;

  modport source (output valid, collision_flag, input ready);
  modport sink   (input valid, collision_flag, output ready);
endinterface

FILE: rtl/core/lpcz_cfg.sv
// Config registers and the zone bounds precomputed from them.
// Depends on lpcz_pkg.
module lpcz_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lpcz_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lpcz_pkg::CFG_W-1:0]             cfg_wdata_i,
  output lpcz_pkg::zone_t                        caution_zone_o,
  output lpcz_pkg::zone_t [lpcz_pkg::SPEED_BANDS-1:0] danger_zones_o
);
  import lpcz_pkg::*;

  logic signed [12:0] offset_q, offset_d;
  logic        [12:0] length_q, length_d;
  logic        [11:0] width_q, width_d;
  logic signed [13:0] cfront_q, cfront_d;
  logic signed [12:0] cside_q, cside_d;
  logic signed [12:0] crear_q, crear_d;
  logic        [12:0] crad_q, crad_d;
  logic [CFG_W-1:0]   table_q, table_d;

  zone_t                     caution_q, caution_d;
  zone_t [SPEED_BANDS-1:0]   danger_q, danger_d;

  // Register write decode
  always_comb begin
    offset_d = offset_q;
    length_d = length_q;
    width_d  = width_q;
    cfront_d = cfront_q;
    cside_d  = cside_q;
    crear_d  = crear_q;
    crad_d   = crad_q;
    table_d  = table_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REAR_OFFSET:  offset_d = signed'(cfg_wdata_i[12:0]);
        CFG_VEH_LENGTH:   length_d = cfg_wdata_i[12:0];
        CFG_VEH_WIDTH:    width_d  = cfg_wdata_i[11:0];
        CFG_CAU_FRONT:    cfront_d = signed'(cfg_wdata_i[13:0]);
        CFG_CAU_SIDE:     cside_d  = signed'(cfg_wdata_i[12:0]);
        CFG_CAU_REAR:     crear_d  = signed'(cfg_wdata_i[12:0]);
        CFG_CAU_RADIUS:   crad_d   = cfg_wdata_i[12:0];
        CFG_DANGER_TABLE: table_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bounds follow the new register values in the same write beat
  always_comb begin
    caution_d = caution_zone(offset_d, length_d, width_d, cfront_d, cside_d, crear_d, crad_d);
    for (int b = 0; b < SPEED_BANDS; b++) begin
      danger_d[b] = danger_zone(offset_d, length_d, width_d, table_d[16*b +: 16]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= RST_REAR_OFFSET;
      length_q  <= RST_VEH_LENGTH;
      width_q   <= RST_VEH_WIDTH;
      cfront_q  <= RST_CAU_FRONT;
      cside_q   <= RST_CAU_SIDE;
      crear_q   <= RST_CAU_REAR;
      crad_q    <= RST_CAU_RADIUS;
      table_q   <= RST_DANGER_TABLE;
      caution_q <= caution_zone(RST_REAR_OFFSET, RST_VEH_LENGTH, RST_VEH_WIDTH,
                                RST_CAU_FRONT, RST_CAU_SIDE, RST_CAU_REAR, RST_CAU_RADIUS);
      for (int b = 0; b < SPEED_BANDS; b++) begin
        danger_q[b] <= danger_zone(RST_REAR_OFFSET, RST_VEH_LENGTH, RST_VEH_WIDTH,
                                   RST_DANGER_TABLE[16*b +: 16]);
      end
    end else begin
      offset_q  <= offset_d;
      length_q  <= length_d;
      width_q   <= width_d;
      cfront_q  <= cfront_d;
      cside_q   <= cside_d;
      crear_q   <= crear_d;
      crad_q    <= crad_d;
      table_q   <= table_d;
      caution_q <= caution_d;
      danger_q  <= danger_d;
    end
  end

  assign caution_zone_o = caution_q;
  assign danger_zones_o = danger_q;

endmodule

FILE: rtl/core/lpcz_zone.sv
// Point-in-zone test: rectangle plus the half-disc ahead of its front.
// Depends on lpcz_pkg.
module lpcz_zone (
  input  logic signed [15:0]         x_i,
  input  logic signed [15:0]         y_i,
  input  logic [30:0]                y_sq_i,
  input  lpcz_pkg::zone_t            zone_i,
  output logic                       hit_o
);
  import lpcz_pkg::*;

  logic signed [COORD_W-1:0] x_e, y2_e, dx;
  logic                      in_rect, ahead;
  logic [31:0]               dx_sq;
  logic [DIST_W-1:0]         dist_sum;

  // Rectangle; y compared at doubled scale against twice the half-width
  always_comb begin
    x_e     = COORD_W'(x_i);
    y2_e    = COORD_W'(y_i) <<< 1;
    in_rect = (x_e >= zone_i.rear) && (x_e <= zone_i.front) &&
              (y2_e >= -zone_i.half2) && (y2_e <= zone_i.half2);
  end

  // Half-disc ahead of the front; dx fits 16 unsigned bits when ahead
  always_comb begin
    ahead    = x_e >= zone_i.front;
    dx       = x_e - zone_i.front;
    dx_sq    = 32'(dx[15:0]) * 32'(dx[15:0]);
    dist_sum = {1'b0, dx_sq} + {2'b0, y_sq_i};
  end

  assign hit_o = in_rect || (ahead && dist_sum <= DIST_W'(zone_i.rad_sq));

endmodule

FILE: rtl/core/lidar_point_collision_zone_classifier.sv
// Lidar point collision zone classifier: top level.
// Input register, then result register; one item per cycle unless a result stalls.
// A speed beat sets the band used by the very next point.
// Reset: config returns to defaults, band to lowest, cluster flags cleared, no result held.
// Depends on lpcz_pkg, lpcz_if, lpcz_cfg and lpcz_zone.
module lidar_point_collision_zone_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lpcz_in_if.sink                       pt_in,
  lpcz_out_if.source                    res_out,
  input  logic                          cfg_we_i,
  input  logic [lpcz_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpcz_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import lpcz_pkg::*;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } item_t;

  zone_t                   caution_zone;
  zone_t [SPEED_BANDS-1:0] danger_zones;

  logic        in_vld_q;
  item_t       in_q;
  logic        in_take;

  logic [BAND_W-1:0] band_q, band_d;
  logic        seen_danger_q, seen_danger_d;
  logic        seen_caution_q, seen_caution_d;
  logic        out_vld_q, out_vld_d;
  flag_e       flag_q, flag_d;

  mode_e       cur_mode;
  logic        gives_result, out_free, s1_fire;
  logic        is_point;
  logic signed [31:0] vx_sq, vy_sq, y_sq_s;
  logic [SPD_W-1:0]   s2;
  logic        hit_danger, hit_caution;
  logic        danger_nx, caution_nx;

  lpcz_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .caution_zone_o (caution_zone),
    .danger_zones_o (danger_zones)
  );

  // Handshake: stage 1 moves on unless its result cannot enter the output register
  always_comb begin
    cur_mode     = mode_e'(in_q.mode);
    is_point     = in_vld_q && (cur_mode == MODE_POINT);
    gives_result = (cur_mode == MODE_EMPTY) || ((cur_mode == MODE_POINT) && in_q.last_point);
    out_free     = !out_vld_q || res_out.ready;
    s1_fire      = in_vld_q && (!gives_result || out_free);
  end

  assign pt_in.ready = !in_vld_q || s1_fire;
  assign in_take     = pt_in.valid && pt_in.ready;

  // Speed squares for the band decision; y square shared by both zone tests
  always_comb begin
    vx_sq  = 32'(in_q.speed_x) * 32'(in_q.speed_x);
    vy_sq  = 32'(in_q.speed_y) * 32'(in_q.speed_y);
    y_sq_s = 32'(in_q.point_y) * 32'(in_q.point_y);
    s2     = {1'b0, vx_sq[30:0]} + {1'b0, vy_sq[30:0]};
  end

  lpcz_zone u_danger (
    .x_i    (in_q.point_x),
    .y_i    (in_q.point_y),
    .y_sq_i (y_sq_s[30:0]),
    .zone_i (danger_zones[band_q]),
    .hit_o  (hit_danger)
  );

  lpcz_zone u_caution (
    .x_i    (in_q.point_x),
    .y_i    (in_q.point_y),
    .y_sq_i (y_sq_s[30:0]),
    .zone_i (caution_zone),
    .hit_o  (hit_caution)
  );

  // Cluster flags: once danger is seen, later points change nothing
  always_comb begin
    danger_nx  = seen_danger_q || hit_danger;
    caution_nx = seen_caution_q || (!seen_danger_q && !hit_danger && hit_caution);
  end

  // Next state and result
  always_comb begin
    band_d         = band_q;
    seen_danger_d  = seen_danger_q;
    seen_caution_d = seen_caution_q;
    flag_d         = flag_q;
    out_vld_d      = out_vld_q && !res_out.ready;
    if (s1_fire) begin
      case (cur_mode)
        MODE_SPEED: band_d = band_of(s2);
        MODE_POINT: begin
          if (in_q.last_point) begin
            seen_danger_d  = 1'b0;
            seen_caution_d = 1'b0;
            out_vld_d      = 1'b1;
            flag_d         = danger_nx ? FLAG_DANGER : (caution_nx ? FLAG_CAUTION : FLAG_CLEAR);
          end else begin
            seen_danger_d  = danger_nx;
            seen_caution_d = caution_nx;
          end
        end
        MODE_EMPTY: begin
          seen_danger_d  = 1'b0;
          seen_caution_d = 1'b0;
          out_vld_d      = 1'b1;
          flag_d         = FLAG_CLEAR;
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      band_q         <= '0;
      seen_danger_q  <= 1'b0;
      seen_caution_q <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      in_vld_q       <= in_take || (in_vld_q && !s1_fire);
      band_q         <= band_d;
      seen_danger_q  <= seen_danger_d;
      seen_caution_q <= seen_caution_d;
      out_vld_q      <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.mode       <= pt_in.mode;
      in_q.speed_x    <= pt_in.speed_x;
      in_q.speed_y    <= pt_in.speed_y;
      in_q.point_x    <= pt_in.point_x;
      in_q.point_y    <= pt_in.point_y;
      in_q.last_point <= pt_in.last_point;
    end
    flag_q <= flag_d;
  end

  assign res_out.valid          = out_vld_q;
  assign res_out.collision_flag = flag_q;

  // An empty-cluster beat always yields a clear result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && cur_mode == MODE_EMPTY) |=> (out_vld_q && flag_q == FLAG_CLEAR))
    else $error("empty cluster did not yield a clear result");

  // A stalled result is never overwritten by a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_out.ready) |-> !(s1_fire && gives_result))
    else $error("pending result overwritten");

  // Stored band stays within the configured number of bands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(band_q) < SPEED_BANDS))
    else $error("speed band out of range");

  // A point stalled in stage 1 leaves the cluster flags alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_point && !s1_fire) |=> ($stable(seen_danger_q) && $stable(seen_caution_q)))
    else $error("cluster flags moved while point stalled");

endmodule
